// ----- rtl/i2c_master_bit_engine_unit_macros.svh -----
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define I2CMBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cmbe assertion failed");

// next-cycle implication, disabled in reset
`define I2CMBE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cmbe assertion failed");

`endif

// ----- rtl/i2cmbe_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, register indexes and the types shared by the engine files.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

    localparam int unsigned CMD_W      = 3;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned POLL_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_ACK  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_NACK = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT = 1'd1;

    localparam logic [DELAY_W-1:0] DELAY_TICKS_RST    = 16'd1;
    localparam logic [POLL_W-1:0]  ACK_POLL_LIMIT_RST = 8'd50;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_ticks;
        logic [POLL_W-1:0]  ack_poll_limit;
    } t_cfg;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_byte;
        logic              ack_seen;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/i2cmbe_engine.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine sequencer
// Phase machine, delay counter, bit shifter and acknowledge polling; one
// update per accepted transaction, result held in the state registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_engine (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_step,
    input  wire  [i2cmbe_pkg::CMD_W-1:0]       i_command,
    input  wire  [i2cmbe_pkg::BYTE_W-1:0]      i_write_data,
    input  wire                                i_sda_in,
    input  i2cmbe_pkg::t_cfg                   i_cfg,
    output i2cmbe_pkg::t_result                o_result
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_SP1, PH_SP2,
        PH_WB, PH_WH, PH_WL, PH_AK0, PH_AK1, PH_AKP, PH_AKE,
        PH_RB, PH_RH, PH_RL, PH_MA0, PH_MA1, PH_MA2
    } t_phase;

    t_phase                             r_phase, n_phase;
    logic [i2cmbe_pkg::CMD_W-1:0]       r_op_kind, n_op_kind;
    logic [i2cmbe_pkg::DELAY_W-1:0]     r_wait, n_wait;
    logic [3:0]                         r_bit, n_bit;
    logic [i2cmbe_pkg::POLL_W-1:0]      r_poll, n_poll;
    logic [i2cmbe_pkg::BYTE_W-1:0]      r_shift, n_shift;
    logic                               r_scl, n_scl;
    logic                               r_sda, n_sda;
    logic                               r_sda_oe, n_sda_oe;
    logic [i2cmbe_pkg::BYTE_W-1:0]      r_rx_byte, n_rx_byte;
    logic                               r_ack, n_ack;
    logic                               r_done, n_done;

    logic [i2cmbe_pkg::DELAY_W-1:0]     w_delay;
    logic [i2cmbe_pkg::DELAY_W-1:0]     w_wait_dec;
    logic [3:0]                         w_bit_inc;
    logic [i2cmbe_pkg::POLL_W-1:0]      w_poll_cur;

    assign w_delay    = (i_cfg.delay_ticks == '0) ? i2cmbe_pkg::DELAY_W'(1)
                                                  : i_cfg.delay_ticks;
    assign w_wait_dec = r_wait - i2cmbe_pkg::DELAY_W'(1);
    assign w_bit_inc  = r_bit + 4'd1;
    assign w_poll_cur = (r_phase == PH_AK1) ? '0 : r_poll;

    always_comb begin
        n_phase   = r_phase;
        n_op_kind = r_op_kind;
        n_wait    = r_wait;
        n_bit     = r_bit;
        n_poll    = r_poll;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_sda_oe  = r_sda_oe;
        n_rx_byte = r_rx_byte;
        n_ack     = r_ack;
        n_done    = r_done;
        if (i_step) begin
            n_done = 1'b0;
            if (r_phase == PH_IDLE) begin
                unique case (i_command)
                    i2cmbe_pkg::CMD_START: begin
                        n_op_kind = i_command;
                        n_sda_oe  = 1'b1;
                        n_sda     = 1'b1;
                        n_scl     = 1'b1;
                        n_phase   = PH_ST1;
                        n_wait    = w_delay;
                    end
                    i2cmbe_pkg::CMD_STOP: begin
                        n_op_kind = i_command;
                        n_sda_oe  = 1'b1;
                        n_sda     = 1'b0;
                        n_scl     = 1'b1;
                        n_phase   = PH_SP1;
                        n_wait    = w_delay;
                    end
                    i2cmbe_pkg::CMD_WRITE: begin
                        n_op_kind = i_command;
                        n_sda_oe  = 1'b1;
                        n_ack     = 1'b0;
                        n_bit     = '0;
                        n_sda     = i_write_data[7];
                        n_shift   = {i_write_data[6:0], 1'b0};
                        n_phase   = PH_WB;
                        n_wait    = w_delay;
                    end
                    i2cmbe_pkg::CMD_READ_ACK, i2cmbe_pkg::CMD_READ_NACK: begin
                        n_op_kind = i_command;
                        n_sda_oe  = 1'b0;
                        n_bit     = '0;
                        n_shift   = '0;
                        n_phase   = PH_RB;
                        n_wait    = w_delay;
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_wait = w_wait_dec;
                if (w_wait_dec == '0) begin
                    unique case (r_phase)
                        PH_ST1: begin
                            n_sda = 1'b0; n_phase = PH_ST2; n_wait = w_delay;
                        end
                        PH_ST2: begin
                            n_scl = 1'b0; n_phase = PH_ST3; n_wait = w_delay;
                        end
                        PH_SP1: begin
                            n_sda = 1'b1; n_phase = PH_SP2; n_wait = w_delay;
                        end
                        PH_SP2: begin
                            n_sda_oe = 1'b0; n_phase = PH_IDLE; n_done = 1'b1;
                        end
                        PH_WB: begin
                            n_scl = 1'b1; n_phase = PH_WH; n_wait = w_delay;
                        end
                        PH_WH: begin
                            n_scl = 1'b0; n_phase = PH_WL; n_wait = w_delay;
                        end
                        PH_WL: begin
                            n_bit  = w_bit_inc;
                            n_wait = w_delay;
                            if (w_bit_inc < 4'd8) begin
                                n_sda   = r_shift[7];
                                n_shift = {r_shift[6:0], 1'b0};
                                n_phase = PH_WB;
                            end else begin
                                n_sda_oe = 1'b0;
                                n_sda    = 1'b1;
                                n_phase  = PH_AK0;
                            end
                        end
                        PH_AK0: begin
                            n_scl = 1'b1; n_phase = PH_AK1; n_wait = w_delay;
                        end
                        PH_AK1, PH_AKP: begin
                            n_wait = w_delay;
                            n_poll = w_poll_cur;
                            if (w_poll_cur >= i_cfg.ack_poll_limit) begin
                                n_ack   = 1'b0;
                                n_scl   = 1'b0;
                                n_phase = PH_AKE;
                            end else if (!i_sda_in) begin
                                n_ack   = 1'b1;
                                n_scl   = 1'b0;
                                n_phase = PH_AKE;
                            end else begin
                                n_poll  = w_poll_cur + i2cmbe_pkg::POLL_W'(1);
                                n_phase = PH_AKP;
                            end
                        end
                        PH_AKE: begin
                            n_sda_oe = 1'b1; n_phase = PH_IDLE; n_done = 1'b1;
                        end
                        PH_RB: begin
                            n_scl = 1'b1; n_phase = PH_RH; n_wait = w_delay;
                        end
                        PH_RH: begin
                            n_shift = {r_shift[6:0], i_sda_in};
                            n_scl   = 1'b0;
                            n_phase = PH_RL;
                            n_wait  = w_delay;
                        end
                        PH_RL: begin
                            n_bit  = w_bit_inc;
                            n_wait = w_delay;
                            if (w_bit_inc < 4'd8) begin
                                n_phase = PH_RB;
                            end else begin
                                n_rx_byte = r_shift;
                                n_sda_oe  = 1'b1;
                                n_sda     = (r_op_kind == i2cmbe_pkg::CMD_READ_NACK);
                                n_phase   = PH_MA0;
                            end
                        end
                        PH_MA0: begin
                            n_scl = 1'b1; n_phase = PH_MA1; n_wait = w_delay;
                        end
                        PH_MA1: begin
                            n_scl = 1'b0; n_phase = PH_MA2; n_wait = w_delay;
                        end
                        default: begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_op_kind <= '0;
            r_wait    <= '0;
            r_bit     <= '0;
            r_poll    <= '0;
            r_shift   <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_sda_oe  <= 1'b0;
            r_rx_byte <= '0;
            r_ack     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_op_kind <= n_op_kind;
            r_wait    <= n_wait;
            r_bit     <= n_bit;
            r_poll    <= n_poll;
            r_shift   <= n_shift;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_sda_oe  <= n_sda_oe;
            r_rx_byte <= n_rx_byte;
            r_ack     <= n_ack;
            r_done    <= n_done;
        end
    end

    assign o_result.scl_level = r_scl;
    assign o_result.sda_level = r_sda;
    assign o_result.sda_drive = r_sda_oe;
    assign o_result.busy_res  = (r_phase != PH_IDLE);
    assign o_result.done_res  = r_done;
    assign o_result.read_byte = r_rx_byte;
    assign o_result.ack_seen  = r_ack;

endmodule

`default_nettype wire

// ----- rtl/i2c_master_bit_engine_unit.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine
// Command and tick driven I2C master: start, stop, byte write with
// acknowledge polling, byte read with master ACK or NACK.
//
//   channel   direction   handshake                 payload
//   in        sink        i_in_valid / o_in_stall   i_command, i_write_data, i_sda_in
//   out       source      o_out_valid / i_out_stall o_scl_level .. o_ack_seen
//   cfg       sink        i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One transaction per cycle; its result is registered and shows the cycle after.
// Throughput is one phase machine step per cycle, held off while o_in_stall is high.
// A new transaction is taken while the result register is empty or being taken.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  [i2cmbe_pkg::CMD_W-1:0]        i_command,
    input  wire  [i2cmbe_pkg::BYTE_W-1:0]       i_write_data,
    input  wire                                 i_sda_in,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic                                o_scl_level,
    output logic                                o_sda_level,
    output logic                                o_sda_drive,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [i2cmbe_pkg::BYTE_W-1:0]       o_read_byte,
    output logic                                o_ack_seen,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [i2cmbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [i2cmbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic                 r_out_valid;
    i2cmbe_pkg::t_cfg     r_cfg;
    i2cmbe_pkg::t_result  w_result;
    logic                 w_in_accept;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_ticks    <= i2cmbe_pkg::DELAY_TICKS_RST;
            r_cfg.ack_poll_limit <= i2cmbe_pkg::ACK_POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                i2cmbe_pkg::CFG_DELAY_TICKS:
                    r_cfg.delay_ticks <= i_cfg_data[i2cmbe_pkg::DELAY_W-1:0];
                i2cmbe_pkg::CFG_ACK_POLL_LIMIT:
                    r_cfg.ack_poll_limit <= i_cfg_data[i2cmbe_pkg::POLL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    i2cmbe_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_in_accept),
        .i_command    (i_command),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .i_cfg        (r_cfg),
        .o_result     (w_result)
    );

    assign o_out_valid = r_out_valid;
    assign o_scl_level = w_result.scl_level;
    assign o_sda_level = w_result.sda_level;
    assign o_sda_drive = w_result.sda_drive;
    assign o_busy_res  = w_result.busy_res;
    assign o_done_res  = w_result.done_res;
    assign o_read_byte = w_result.read_byte;
    assign o_ack_seen  = w_result.ack_seen;

endmodule

`default_nettype wire

// ----- rtl/i2cmbe_checker.sv -----
// ----------------------------------------------------------------------------
// I2C master bit engine port checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_engine_unit_macros.svh"

module i2cmbe_assertions (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 i_in_valid,
    input wire                                 o_in_stall,
    input wire                                 o_out_valid,
    input wire                                 i_out_stall,
    input wire                                 o_busy_res,
    input wire                                 o_done_res,
    input wire  [i2cmbe_pkg::BYTE_W-1:0]       o_read_byte
);

    `I2CMBE_ASSERT_NXT(a_accept_gives_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid)
    `I2CMBE_ASSERT_IMP(a_done_means_idle, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res)
    `I2CMBE_ASSERT_IMP(a_full_stall_blocks_input, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `I2CMBE_ASSERT_NXT(a_stalled_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_byte) && $stable(o_done_res))

endmodule

bind i2c_master_bit_engine_unit i2cmbe_assertions u_i2cmbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_read_byte (o_read_byte)
);

`default_nettype wire

// ----- dv/i2cmbe_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine checker
// Watches the command, result and register channels, runs its own copy of the
// engine's phase machine on every accepted transaction and compares each
// accepted result against the oldest predicted pin and status state.
// ----------------------------------------------------------------------------

module i2cmbe_checker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_in_valid,
    input  wire                                 i_in_stall,
    input  wire  [i2cmbe_pkg::CMD_W-1:0]        i_command,
    input  wire  [i2cmbe_pkg::BYTE_W-1:0]       i_write_data,
    input  wire                                 i_sda_in,
    input  wire                                 i_out_valid,
    input  wire                                 i_out_stall,
    input  wire                                 i_scl_level,
    input  wire                                 i_sda_level,
    input  wire                                 i_sda_drive,
    input  wire                                 i_busy_res,
    input  wire                                 i_done_res,
    input  wire  [i2cmbe_pkg::BYTE_W-1:0]       i_read_byte,
    input  wire                                 i_ack_seen,
    input  wire                                 i_cfg_valid,
    input  wire                                 i_cfg_ready,
    input  wire  [i2cmbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [i2cmbe_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                  o_err_count,
    output int                                  o_pending
);

    import i2cmbe_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ST1, S_ST2, S_ST3, S_SP1, S_SP2,
        S_WB, S_WH, S_WL, S_AK0, S_AK1, S_AKP, S_AKE,
        S_RB, S_RH, S_RL, S_MA0, S_MA1, S_MA2
    } t_phase;

    logic [DELAY_W-1:0] cfg_delay;
    logic [POLL_W-1:0]  cfg_limit;

    t_phase             phase;
    logic [CMD_W-1:0]   op_kind;
    logic [DELAY_W-1:0] wait_cnt;
    logic [3:0]         bit_idx;
    logic [POLL_W-1:0]  poll_cnt;
    logic [BYTE_W-1:0]  shreg;
    logic               scl_q;
    logic               sda_q;
    logic               sda_oe;
    logic [BYTE_W-1:0]  rx_q;
    logic               ack_q;

    t_result            line_state_q[$];
    int                 err_cnt = 0;

    initial begin
        o_err_count = 0;
        o_pending   = 0;
    end

    function automatic void load_wait(input t_phase nxt);
        phase    = nxt;
        wait_cnt = (cfg_delay == '0) ? DELAY_W'(1) : cfg_delay;
    endfunction

    function automatic void shift_out();
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
    endfunction

    function automatic void poll_ack(input logic sda);
        if (poll_cnt >= cfg_limit) begin
            ack_q = 1'b0;
            scl_q = 1'b0;
            load_wait(S_AKE);
        end else if (!sda) begin
            ack_q = 1'b1;
            scl_q = 1'b0;
            load_wait(S_AKE);
        end else begin
            poll_cnt = poll_cnt + 1'b1;
            load_wait(S_AKP);
        end
    endfunction

    // advance the phase machine once the delay interval has run out
    function automatic logic step_phase(input logic sda);
        logic fin;
        fin = 1'b0;
        case (phase)
            S_ST1: begin sda_q = 1'b0; load_wait(S_ST2); end
            S_ST2: begin scl_q = 1'b0; load_wait(S_ST3); end
            S_SP1: begin sda_q = 1'b1; load_wait(S_SP2); end
            S_SP2: begin sda_oe = 1'b0; phase = S_IDLE; fin = 1'b1; end
            S_WB:  begin scl_q = 1'b1; load_wait(S_WH); end
            S_WH:  begin scl_q = 1'b0; load_wait(S_WL); end
            S_WL: begin
                bit_idx = bit_idx + 1'b1;
                if (bit_idx < 4'd8) begin
                    shift_out();
                    load_wait(S_WB);
                end else begin
                    sda_oe = 1'b0;
                    sda_q  = 1'b1;
                    load_wait(S_AK0);
                end
            end
            S_AK0: begin scl_q = 1'b1; load_wait(S_AK1); end
            S_AK1: begin poll_cnt = '0; poll_ack(sda); end
            S_AKP: poll_ack(sda);
            S_AKE: begin sda_oe = 1'b1; phase = S_IDLE; fin = 1'b1; end
            S_RB:  begin scl_q = 1'b1; load_wait(S_RH); end
            S_RH: begin
                shreg = {shreg[6:0], sda};
                scl_q = 1'b0;
                load_wait(S_RL);
            end
            S_RL: begin
                bit_idx = bit_idx + 1'b1;
                if (bit_idx < 4'd8) begin
                    load_wait(S_RB);
                end else begin
                    rx_q   = shreg;
                    sda_oe = 1'b1;
                    sda_q  = (op_kind == CMD_READ_NACK);
                    load_wait(S_MA0);
                end
            end
            S_MA0: begin scl_q = 1'b1; load_wait(S_MA1); end
            S_MA1: begin scl_q = 1'b0; load_wait(S_MA2); end
            default: begin phase = S_IDLE; fin = 1'b1; end
        endcase
        return fin;
    endfunction

    function automatic t_result engine_step(input logic [CMD_W-1:0] cmd,
                                            input logic [BYTE_W-1:0] data,
                                            input logic sda);
        t_result r;
        logic    fin;
        fin = 1'b0;
        if (phase == S_IDLE) begin
            if (cmd >= CMD_START && cmd <= CMD_READ_NACK) begin
                op_kind = cmd;
                case (cmd)
                    CMD_START: begin
                        sda_oe = 1'b1; sda_q = 1'b1; scl_q = 1'b1;
                        load_wait(S_ST1);
                    end
                    CMD_STOP: begin
                        sda_oe = 1'b1; sda_q = 1'b0; scl_q = 1'b1;
                        load_wait(S_SP1);
                    end
                    CMD_WRITE: begin
                        sda_oe  = 1'b1;
                        ack_q   = 1'b0;
                        bit_idx = '0;
                        shreg   = data;
                        shift_out();
                        load_wait(S_WB);
                    end
                    default: begin
                        sda_oe  = 1'b0;
                        bit_idx = '0;
                        shreg   = '0;
                        load_wait(S_RB);
                    end
                endcase
            end
        end else begin
            wait_cnt = wait_cnt - 1'b1;
            if (wait_cnt == '0)
                fin = step_phase(sda);
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.sda_drive = sda_oe;
        r.busy_res  = (phase != S_IDLE);
        r.done_res  = fin;
        r.read_byte = rx_q;
        r.ack_seen  = ack_q;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : chk_proc
        t_result want;
        if (!i_rst_n) begin
            cfg_delay = DELAY_TICKS_RST;
            cfg_limit = ACK_POLL_LIMIT_RST;
            phase     = S_IDLE;
            op_kind   = '0;
            wait_cnt  = '0;
            bit_idx   = '0;
            poll_cnt  = '0;
            shreg     = '0;
            scl_q     = 1'b1;
            sda_q     = 1'b1;
            sda_oe    = 1'b0;
            rx_q      = '0;
            ack_q     = 1'b0;
            line_state_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (line_state_q.size() == 0) begin
                    $display("%t: result with no transaction pending", $realtime);
                    err_cnt++;
                end else begin
                    want = line_state_q.pop_front();
                    check_field("scl_level", want.scl_level, i_scl_level);
                    check_field("sda_level", want.sda_level, i_sda_level);
                    check_field("sda_drive", want.sda_drive, i_sda_drive);
                    check_field("busy_res",  want.busy_res,  i_busy_res);
                    check_field("done_res",  want.done_res,  i_done_res);
                    check_field("read_byte", want.read_byte, i_read_byte);
                    check_field("ack_seen",  want.ack_seen,  i_ack_seen);
                end
            end
            if (i_in_valid && !i_in_stall)
                line_state_q.push_back(engine_step(i_command, i_write_data, i_sda_in));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_DELAY_TICKS)
                    cfg_delay = i_cfg_data[DELAY_W-1:0];
                else
                    cfg_limit = i_cfg_data[POLL_W-1:0];
            end
        end
        o_pending   <= line_state_q.size();
        o_err_count <= err_cnt;
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master bit engine testbench
// Drives start, stop, write and read sequences padded with tick transactions,
// with random SDA levels, idle gaps and result stalls, across several delay
// and acknowledge poll settings; a checker module predicts every result.
// ----------------------------------------------------------------------------

module tb_top;

    import i2cmbe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    typedef enum int {SDA_RAND, SDA_MOSTLY_HIGH, SDA_HIGH, SDA_LOW} t_sda_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_command;
    logic [BYTE_W-1:0]     i_write_data;
    logic                  i_sda_in;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_scl_level;
    logic                  o_sda_level;
    logic                  o_sda_drive;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [BYTE_W-1:0]     o_read_byte;
    logic                  o_ack_seen;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int chk_errors;
    int chk_pending;
    int done_cnt   = 0;
    int stall_left = 0;
    int n_items    = 0;
    bit gaps_on    = 1'b1;
    bit stall_on   = 1'b1;
    bit noise_on   = 1'b0;

    i2c_master_bit_engine_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_sda_drive  (o_sda_drive),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_read_byte  (o_read_byte),
        .o_ack_seen   (o_ack_seen),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    i2cmbe_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_scl_level  (o_scl_level),
        .i_sda_level  (o_sda_level),
        .i_sda_drive  (o_sda_drive),
        .i_busy_res   (o_busy_res),
        .i_done_res   (o_done_res),
        .i_read_byte  (o_read_byte),
        .i_ack_seen   (o_ack_seen),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_err_count  (chk_errors),
        .o_pending    (chk_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic sda_bit(input t_sda_mode mode);
        case (mode)
            SDA_HIGH:        return 1'b1;
            SDA_LOW:         return 1'b0;
            SDA_MOSTLY_HIGH: return ($urandom_range(0, 11) != 0);
            default:         return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // hold result stalls in runs of random length
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (stall_on && $urandom_range(0, 5) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall && o_done_res)
            done_cnt <= done_cnt + 1;
    end

    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                             input logic sda);
        int gap;
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_write_data <= data;
        i_sda_in     <= sda;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_items++;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // issue one command, then tick until its completion shows on the result side
    task automatic run_txn(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                           input t_sda_mode mode);
        int               target;
        logic [CMD_W-1:0] tick_cmd;
        target = done_cnt + 1;
        send_item(cmd, data, sda_bit(mode));
        while (done_cnt < target) begin
            tick_cmd = CMD_TICK;
            if (noise_on && $urandom_range(0, 24) == 0)
                tick_cmd = CMD_W'($urandom_range(1, 7));
            send_item(tick_cmd, BYTE_W'($urandom), sda_bit(mode));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int                    rand_base;
        int                    r;
        int                    r2;
        logic [CMD_W-1:0]      cmd;
        logic [CFG_DATA_W-1:0] dly;
        logic [CFG_DATA_W-1:0] lim_word;
        t_sda_mode             mode;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_command    = CMD_TICK;
        i_write_data = '0;
        i_sda_in     = 1'b0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_DELAY_TICKS;
        i_cfg_data   = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: idle ticks, reserved codes, every command
        send_item(CMD_TICK, 8'h00, 1'b0);
        send_item(CMD_RSVD6, 8'hFF, 1'b1);
        send_item(CMD_RSVD7, 8'h5A, 1'b0);
        run_txn(CMD_START, 8'h00, SDA_RAND);
        run_txn(CMD_WRITE, 8'h00, SDA_LOW);
        run_txn(CMD_WRITE, 8'hFF, SDA_HIGH);
        run_txn(CMD_WRITE, 8'hA5, SDA_MOSTLY_HIGH);
        run_txn(CMD_READ_ACK, 8'h00, SDA_RAND);
        run_txn(CMD_READ_NACK, 8'hFF, SDA_HIGH);
        run_txn(CMD_READ_ACK, 8'h00, SDA_LOW);
        noise_on = 1'b1;
        run_txn(CMD_WRITE, 8'h3C, SDA_RAND);
        run_txn(CMD_STOP, 8'h00, SDA_RAND);

        // zero delay and zero poll limit
        write_reg(CFG_DELAY_TICKS, 16'h0000);
        write_reg(CFG_ACK_POLL_LIMIT, 16'hFF00);
        run_txn(CMD_START, 8'h00, SDA_RAND);
        run_txn(CMD_WRITE, 8'h81, SDA_LOW);
        run_txn(CMD_WRITE, 8'h7E, SDA_HIGH);
        run_txn(CMD_READ_NACK, 8'h00, SDA_RAND);
        run_txn(CMD_STOP, 8'h00, SDA_RAND);

        // longest acknowledge wait
        write_reg(CFG_DELAY_TICKS, 16'h0001);
        write_reg(CFG_ACK_POLL_LIMIT, 16'h00FF);
        run_txn(CMD_WRITE, 8'hC3, SDA_HIGH);
        run_txn(CMD_WRITE, 8'h18, SDA_MOSTLY_HIGH);

        // long delay interval reaching the upper byte, driven at full rate
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        noise_on = 1'b0;
        write_reg(CFG_DELAY_TICKS, 16'h0101);
        write_reg(CFG_ACK_POLL_LIMIT, 16'hA503);
        run_txn(CMD_STOP, 8'h00, SDA_RAND);

        rand_base = n_items;
        for (int p = 0; p < 4; p++) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                dly = 16'd1;
            else if (r < 75)
                dly = 16'd2;
            else if (r < 87)
                dly = 16'd0;
            else
                dly = CFG_DATA_W'($urandom_range(3, 5));
            lim_word = CFG_DATA_W'($urandom);
            r = $urandom_range(0, 99);
            if (r < 30)
                lim_word[7:0] = POLL_W'($urandom_range(0, 3));
            else if (r < 70)
                lim_word[7:0] = POLL_W'($urandom_range(4, 60));
            else if (r < 80)
                lim_word[7:0] = 8'hFF;
            else
                lim_word[7:0] = POLL_W'($urandom_range(0, 255));
            write_reg(CFG_DELAY_TICKS, dly);
            write_reg(CFG_ACK_POLL_LIMIT, lim_word);
            gaps_on  = ($urandom_range(0, 4) != 0);
            stall_on = ($urandom_range(0, 4) != 0);
            noise_on = 1'b1;

            while (n_items - rand_base < 200 * (p + 1)) begin
                r  = $urandom_range(0, 99);
                r2 = $urandom_range(0, 99);
                if (r2 < 50)
                    mode = SDA_RAND;
                else if (r2 < 75)
                    mode = SDA_MOSTLY_HIGH;
                else if (r2 < 90)
                    mode = SDA_HIGH;
                else
                    mode = SDA_LOW;
                if (r < 8) begin
                    if (r < 3)
                        cmd = CMD_TICK;
                    else if (r < 5)
                        cmd = CMD_RSVD6;
                    else
                        cmd = CMD_RSVD7;
                    send_item(cmd, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    if (r < 22)
                        cmd = CMD_START;
                    else if (r < 36)
                        cmd = CMD_STOP;
                    else if (r < 68)
                        cmd = CMD_WRITE;
                    else if (r < 86)
                        cmd = CMD_READ_ACK;
                    else
                        cmd = CMD_READ_NACK;
                    run_txn(cmd, BYTE_W'($urandom), mode);
                end
            end
        end

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (chk_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
